// ===== rtl/esc_pkg.sv =====
// Shared types and constants for the environmental sensor compensation core.
// Holds the channel payload structs, register indexes and divider sizing.
// No dependencies; every other file in rtl imports this package.
package esc_pkg;

   // Configuration register index width and register codes.
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CALIB    = 3'd0,
      CSR_PRESS_CALIB_A = 3'd1,
      CSR_PRESS_CALIB_B = 3'd2,
      CSR_HUM_CALIB     = 3'd3
   } csr_index_type;

   // Input item: one raw sample set.
   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
      logic [9:0]  raw_gas;
      logic [3:0]  gas_range_code;
   } req_payload_type;

   // Result item: compensated values.
   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic [17:0]        pressure_pa;
      logic               pressure_invalid;
      logic [16:0]        humidity_milli;
      logic [26:0]        gas_ohms;
   } rsp_payload_type;

   // Restoring divider sizing: one quotient bit per stage.
   localparam int DIV_NUM_W  = 60;
   localparam int DIV_DEN_W  = 34;
   localparam int DIV_REM_W  = DIV_DEN_W + 1;
   localparam int DIV_W      = DIV_REM_W + DIV_NUM_W;
   localparam int DIV_STAGES = DIV_NUM_W;

   // Pipeline depth before and after the dividers.
   localparam int PRE_STAGES  = 15;
   localparam int POST_STAGES = 7;
   localparam int LAT         = PRE_STAGES + DIV_STAGES + POST_STAGES;

   // Gas numerator 10^6 * 2^18 before the range shift.
   localparam logic [37:0] GAS_NUM_BASE = 38'd262144000000;

   // Pressure divider operands as they travel toward the divider.
   typedef struct packed {
      logic [DIV_NUM_W-1:0] nmag;
      logic [DIV_DEN_W-1:0] dmag;
      logic                 qneg;
      logic                 inv;
   } div_carry_type;

   // Values that ride alongside the dividers.
   typedef struct packed {
      logic signed [15:0] temp;
      logic [16:0]        hum;
      logic               inv;
      logic               qneg;
   } side_type;

   // Values that ride alongside the pressure correction polynomial.
   typedef struct packed {
      logic signed [15:0] temp;
      logic [16:0]        hum;
      logic               inv;
      logic [26:0]        gas;
   } post_type;

endpackage

// ===== rtl/esc_div.sv =====
// Pipelined restoring divider for unsigned magnitudes, one quotient bit a stage.
// Depends on esc_pkg for operand widths and stage count.
module esc_div import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic [DIV_W-1:0]     work_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_STAGES];
   logic [DIV_W-1:0]     work_in [DIV_STAGES];

   // Each stage shifts the remainder left, brings in one dividend bit and
   // subtracts the divisor when it fits.
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [DIV_W-1:0]     prev;
      logic [DIV_DEN_W-1:0] dsel;
      logic [DIV_W-1:0]     shifted;
      logic [DIV_REM_W-1:0] hi;

      if (i == 0) begin : g_first
         assign prev = {{DIV_REM_W{1'b0}}, dividend};
         assign dsel = divisor;
      end else begin : g_rest
         assign prev = work_ff[i-1];
         assign dsel = den_ff[i-1];
      end

      assign shifted = {prev[DIV_W-2:0], 1'b0};
      assign hi      = shifted[DIV_W-1:DIV_NUM_W];

      always_comb begin
         work_in[i] = shifted;
         if (hi >= {1'b0, dsel}) begin
            work_in[i][DIV_W-1:DIV_NUM_W] = hi - {1'b0, dsel};
            work_in[i][0] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            work_ff[i] <= work_in[i];
            den_ff[i]  <= dsel;
         end
      end
   end

   assign quotient = work_ff[DIV_STAGES-1][DIV_NUM_W-1:0];

endmodule

// ===== rtl/env_sensor_compensation_core.sv =====
// Environmental sensor compensation core: raw samples in, calibrated values out.
// Depends on esc_pkg and instantiates esc_div for pressure and gas.
//
// Usage:
//   Calibration words are written on the csr_ channel (index 0 temperature,
//   1 and 2 pressure, 3 humidity); csr_ready is always high. Write them only
//   while no item is in flight.
//   Each req_ item is one raw sample set; each rsp_ item is the matching
//   compensated result, in order.
//   The pipeline has 15 front stages (temperature, fine temperature,
//   pressure divisor and the humidity polynomial), two 60 stage bit-per-stage
//   dividers running side by side for pressure and gas, and 7 stages of
//   pressure correction and rounding.
//   Throughput is one item per cycle. The whole pipeline advances together:
//   when rsp_valid is high and rsp_ready low it freezes, req_ready drops, and
//   nothing is lost or repeated. Empty slots keep flowing while the output
//   register is empty or being taken.
//   Reset clears the calibration registers to zero and drops all valid bits.
module env_sensor_compensation_core import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers and calibration fields
   // ---------------------------------------------------------------------
   logic [39:0] temp_calib_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [63:0] hum_calib_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         hum_calib_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_CALIB:    temp_calib_ff <= csr_wdata[39:0];
            CSR_PRESS_CALIB_A: press_a_ff    <= csr_wdata;
            CSR_PRESS_CALIB_B: press_b_ff    <= csr_wdata;
            CSR_HUM_CALIB:     hum_calib_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [15:0] t2;
   logic signed [7:0]  t3;
   logic signed [16:0] p1;
   logic signed [15:0] p2, p4, p5, p8, p9;
   logic signed [7:0]  p3, p6, p7;
   logic signed [8:0]  p10;
   logic signed [12:0] h2;
   logic signed [7:0]  h3, h4, h5, h7;

   assign t2  = temp_calib_ff[31:16];
   assign t3  = temp_calib_ff[39:32];
   assign p1  = {1'b0, press_a_ff[15:0]};
   assign p2  = press_a_ff[31:16];
   assign p4  = press_a_ff[47:32];
   assign p5  = press_a_ff[63:48];
   assign p3  = press_b_ff[7:0];
   assign p6  = press_b_ff[15:8];
   assign p7  = press_b_ff[23:16];
   assign p8  = press_b_ff[39:24];
   assign p9  = press_b_ff[55:40];
   assign p10 = {1'b0, press_b_ff[63:56]};
   assign h2  = {1'b0, hum_calib_ff[23:12]};
   assign h3  = hum_calib_ff[31:24];
   assign h4  = hum_calib_ff[39:32];
   assign h5  = hum_calib_ff[47:40];
   assign h7  = hum_calib_ff[63:56];

   // ---------------------------------------------------------------------
   // Pipeline control: all stages move together
   // ---------------------------------------------------------------------
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Front stage combinational logic
   // ---------------------------------------------------------------------
   // Stage 1: temperature offset.
   logic signed [21:0] d_in;
   assign d_in = $signed({2'b00, req_payload.raw_temperature})
               - $signed({2'b00, temp_calib_ff[15:0], 4'h0});

   // Stage 2 products.
   logic signed [21:0] d_ff;
   logic signed [37:0] m1_in, m1_ff;
   logic signed [43:0] dd_in, dd_ff;
   assign m1_in = d_ff * t2;
   assign dd_in = d_ff * d_ff;

   // Stage 3: fine temperature, scaled by 2^30.
   logic signed [51:0] ddt3;
   logic signed [54:0] tf_in, tf_ff;
   assign ddt3  = dd_ff * t3;
   assign tf_in = $signed({m1_ff, 16'h0000}) + ddt3;

   // Stage 4: temperature result, pressure offset term and the magnitude
   // that feeds the divide-by-five for humidity.
   logic signed [57:0] tf5, trnd;
   logic signed [19:0] tsh;
   logic signed [15:0] temp_in;
   logic signed [31:0] vsh, v_in;
   logic signed [30:0] tq, tqm;
   logic               tneg_in, tneg_ff;
   logic [28:0]        m_in, m_ff;

   assign tf5  = (tf_ff <<< 2) + tf_ff;
   assign trnd = tf5 + 58'sh20_0000_0000;
   assign tsh  = trnd[57:38];
   assign vsh  = tf_ff[54:23];
   assign v_in = vsh - 32'sd16384000;
   assign tq   = tf_ff[54:24];
   assign tqm  = 31'sd4 - tq;
   assign tneg_in = tq[30];
   assign m_in    = tneg_in ? tqm[28:0] : tq[28:0];

   always_comb begin
      if (tsh > 20'sd32767) begin
         temp_in = 16'sh7FFF;
      end else if (tsh < -20'sd32768) begin
         temp_in = 16'sh8000;
      end else begin
         temp_in = tsh[15:0];
      end
   end

   // Stage 5: squared offset and floored division of the temperature by five.
   logic signed [31:0] v_ff [2];
   logic signed [63:0] vv_in, vv_ff;
   logic [60:0]        qprod;
   logic [26:0]        qq;
   logic signed [27:0] tt_in, tt_ff;
   assign vv_in = v_ff[0] * v_ff[0];
   assign qprod = m_ff * 32'hCCCC_CCCD;
   assign qq    = qprod[60:34];
   assign tt_in = tneg_ff ? -$signed({1'b0, qq}) : $signed({1'b0, qq});

   // Stage 6: pressure and humidity products.
   logic signed [55:0] v2;
   logic signed [63:0] v2p6_in, v2p6_ff, v2p3_in, v2p3_ff;
   logic signed [47:0] p5v_in, p5v_ff, p2v_in, p2v_ff;
   logic signed [35:0] h3tt_in, h3tt_ff, h4tt_in, h4tt_ff, h7tt_in, h7tt_ff;
   logic signed [55:0] tt2_in, tt2_ff;
   assign v2      = vv_ff[63:8];
   assign v2p6_in = v2 * p6;
   assign v2p3_in = v2 * p3;
   assign p5v_in  = p5 * v_ff[1];
   assign p2v_in  = p2 * v_ff[1];
   assign h3tt_in = h3 * tt_ff;
   assign h4tt_in = h4 * tt_ff;
   assign h7tt_in = h7 * tt_ff;
   assign tt2_in  = tt_ff * tt_ff;

   // Stage 7: pressure offset and sensitivity sums, humidity linear terms.
   logic signed [49:0] asum;
   logic signed [48:0] a_in, a_ff;
   logic signed [50:0] s_in, s_ff;
   logic signed [27:0] hv_in;
   logic signed [31:0] gpre_in, gpre_ff;
   logic signed [39:0] t2s_in, t2s_ff;
   logic signed [27:0] c_in;
   assign asum    = $signed(v2p6_ff[63:17]) + $signed({p5v_ff, 1'b0});
   assign a_in    = $signed(asum[49:2]) + $signed({p4, 24'h000000});
   assign s_in    = $signed(v2p3_ff[63:14]) + p2v_ff;
   assign t2s_in  = tt2_ff[55:16];
   assign gpre_in = 32'sh0100_0000 + $signed(h4tt_ff[35:6]);
   assign c_in    = $signed({6'b0, hum_calib_ff[55:48], 14'h0000})
                  + $signed(h7tt_ff[35:9]);

   // Stage 8: divisor product, dividend and humidity gain.
   req_payload_type    rq_ff [PRE_STAGES-1];
   logic signed [67:0] p1s_in, p1s_ff;
   logic signed [21:0] pd;
   logic signed [49:0] nd;
   logic signed [63:0] num_in;
   logic signed [47:0] t2h5;
   logic signed [36:0] g_in, g_ff;
   assign hv_in  = $signed({4'b0, rq_ff[5].raw_humidity, 8'h00})
                 - $signed({4'b0, hum_calib_ff[11:0], 12'h000})
                 + $signed(h3tt_ff[35:9]);
   assign p1s_in = p1 * s_ff;
   assign pd     = 22'sh10_0000 - $signed({2'b00, rq_ff[6].raw_pressure});
   assign nd     = $signed({pd, 20'h00000}) - a_ff;
   assign num_in = nd * 14'sd6250;
   assign t2h5   = t2s_ff * h5;
   assign g_in   = gpre_ff + $signed(t2h5[47:12]);

   // Stage 9: pressure divisor and humidity scale.
   logic signed [42:0] dq_in, dq_ff;
   logic signed [49:0] gh2;
   logic signed [39:0] k_in, k_ff;
   assign dq_in = $signed({1'b0, press_a_ff[15:0], 16'h0000}) + $signed(p1s_ff[67:26]);
   assign gh2   = g_ff * h2;
   assign k_in  = gh2[49:10];

   // Stage 10: sign and magnitude split for the divider, divisor check.
   logic signed [63:0] num_ff [2];
   logic signed [27:0] hv_ff [3];
   logic signed [38:0] den, dabs;
   logic signed [63:0] nabs;
   div_carry_type      dc_in;
   logic signed [67:0] hk_in, hk_ff;
   assign den  = dq_ff[42:4];
   assign dabs = den[38] ? -den : den;
   assign nabs = num_ff[1][63] ? -num_ff[1] : num_ff[1];
   assign dc_in.nmag = nabs[DIV_NUM_W-1:0];
   assign dc_in.dmag = dabs[DIV_DEN_W-1:0];
   assign dc_in.qneg = num_ff[1][63] ^ den[38];
   assign dc_in.inv  = (dq_ff > -43'sd65536) && (dq_ff < 43'sd65536);
   assign hk_in = hv_ff[2] * k_ff;

   // Stage 11: linear humidity, held to plus or minus 2^36.
   logic signed [51:0] rr;
   logic signed [37:0] r_in;
   assign rr = hk_ff[67:16];
   always_comb begin
      if (rr > 52'sh10_0000_0000) begin
         r_in = 38'sh10_0000_0000;
      end else if (rr < -52'sh10_0000_0000) begin
         r_in = -38'sh10_0000_0000;
      end else begin
         r_in = rr[37:0];
      end
   end

   // Stage 12: square of the scaled linear humidity.
   logic signed [37:0] r_ff [3];
   logic signed [25:0] r12;
   logic signed [51:0] sqp;
   logic signed [39:0] sq_in, sq_ff;
   assign r12   = r_ff[0][37:12];
   assign sqp   = r12 * r12;
   assign sq_in = sqp[51:12];

   // Stage 13: quadratic humidity term.
   logic signed [27:0] c_ff [6];
   logic signed [67:0] cs_in, cs_ff;
   assign cs_in = c_ff[5] * sq_ff;

   // Stage 14: sum and clamp to 0..100 percent.
   logic signed [52:0] usum;
   logic [30:0]        u_in, u_ff;
   assign usum = r_ff[2] + $signed(cs_ff[67:16]);
   always_comb begin
      if (usum < 53'sd0) begin
         u_in = '0;
      end else if (usum > 53'sd1677721600) begin
         u_in = 31'd1677721600;
      end else begin
         u_in = usum[30:0];
      end
   end

   // Stage 15: humidity in milli-percent, gas divider operands.
   logic [41:0] ux, urnd;
   logic [16:0] hum_in, hum_ff;
   logic [12:0] gden_in, gden_ff;
   logic [37:0] gnum_in, gnum_ff;
   assign ux      = u_ff * 11'd1000;
   assign urnd    = ux + 42'h80_0000;
   assign hum_in  = urnd[40:24];
   assign gden_in = {3'b000, rq_ff[13].raw_gas} + {2'b00, rq_ff[13].raw_gas, 1'b0}
                  + 13'd2560;
   assign gnum_in = (GAS_NUM_BASE >> rq_ff[13].gas_range_code) + {26'd0, gden_in[12:1]};

   // ---------------------------------------------------------------------
   // Front stage registers
   // ---------------------------------------------------------------------
   logic signed [15:0] tc_ff [12];
   div_carry_type      dc_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         rq_ff[0] <= req_payload;
         for (int i = 1; i < PRE_STAGES - 1; i++) begin
            rq_ff[i] <= rq_ff[i-1];
         end
         d_ff     <= d_in;
         m1_ff    <= m1_in;
         dd_ff    <= dd_in;
         tf_ff    <= tf_in;
         tc_ff[0] <= temp_in;
         for (int i = 1; i < 12; i++) begin
            tc_ff[i] <= tc_ff[i-1];
         end
         v_ff[0]  <= v_in;
         v_ff[1]  <= v_ff[0];
         tneg_ff  <= tneg_in;
         m_ff     <= m_in;
         vv_ff    <= vv_in;
         tt_ff    <= tt_in;
         v2p6_ff  <= v2p6_in;
         v2p3_ff  <= v2p3_in;
         p5v_ff   <= p5v_in;
         p2v_ff   <= p2v_in;
         h3tt_ff  <= h3tt_in;
         h4tt_ff  <= h4tt_in;
         h7tt_ff  <= h7tt_in;
         tt2_ff   <= tt2_in;
         a_ff     <= a_in;
         s_ff     <= s_in;
         gpre_ff  <= gpre_in;
         t2s_ff   <= t2s_in;
         hv_ff[0] <= hv_in;
         hv_ff[1] <= hv_ff[0];
         hv_ff[2] <= hv_ff[1];
         c_ff[0]  <= c_in;
         for (int i = 1; i < 6; i++) begin
            c_ff[i] <= c_ff[i-1];
         end
         p1s_ff    <= p1s_in;
         num_ff[0] <= num_in;
         num_ff[1] <= num_ff[0];
         g_ff      <= g_in;
         dq_ff     <= dq_in;
         k_ff      <= k_in;
         dc_ff[0]  <= dc_in;
         for (int i = 1; i < 6; i++) begin
            dc_ff[i] <= dc_ff[i-1];
         end
         hk_ff   <= hk_in;
         r_ff[0] <= r_in;
         r_ff[1] <= r_ff[0];
         r_ff[2] <= r_ff[1];
         sq_ff   <= sq_in;
         cs_ff   <= cs_in;
         u_ff    <= u_in;
         hum_ff  <= hum_in;
         gden_ff <= gden_in;
         gnum_ff <= gnum_in;
      end
   end

   // ---------------------------------------------------------------------
   // Dividers with a matching side line
   // ---------------------------------------------------------------------
   logic [DIV_NUM_W-1:0] pquo, gquo;
   side_type             side_ff [DIV_STAGES];
   side_type             side_in;

   esc_div u_press_div (
      .clock    (clock),
      .enable   (adv),
      .dividend (dc_ff[5].nmag),
      .divisor  (dc_ff[5].dmag),
      .quotient (pquo)
   );

   esc_div u_gas_div (
      .clock    (clock),
      .enable   (adv),
      .dividend ({{(DIV_NUM_W-38){1'b0}}, gnum_ff}),
      .divisor  ({{(DIV_DEN_W-13){1'b0}}, gden_ff}),
      .quotient (gquo)
   );

   assign side_in.temp = tc_ff[11];
   assign side_in.hum  = hum_ff;
   assign side_in.inv  = dc_ff[5].inv;
   assign side_in.qneg = dc_ff[5].qneg;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Back stages: pressure correction polynomial
   // ---------------------------------------------------------------------
   // Stage 1: signed first estimate, held to plus or minus 2^31.
   side_type           side_last;
   logic               over;
   logic [31:0]        xm;
   logic signed [32:0] x_in;
   post_type           pt_in;
   assign side_last = side_ff[DIV_STAGES-1];
   assign over = (|pquo[DIV_NUM_W-1:32]) || (pquo[31] && (|pquo[30:0]));
   assign xm   = over ? 32'h8000_0000 : pquo[31:0];
   assign x_in = side_last.qneg ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
   assign pt_in.temp = side_last.temp;
   assign pt_in.hum  = side_last.hum;
   assign pt_in.inv  = side_last.inv;
   assign pt_in.gas  = gquo[26:0];

   // Stage 2: square and linear products.
   logic signed [32:0] x_ff [5];
   logic signed [65:0] xx_in, xx_ff;
   logic signed [24:0] w_in;
   logic signed [48:0] xp8_in;
   assign xx_in  = x_ff[0] * x_ff[0];
   assign w_in   = x_ff[0][32:8];
   assign xp8_in = x_ff[0] * p8;

   // Stage 3: scaled square and square of the coarse estimate.
   logic signed [24:0] w_ff [2];
   logic signed [49:0] q_in, q_ff;
   logic signed [49:0] wsq;
   logic signed [41:0] w2_in, w2_ff;
   assign q_in  = xx_ff[65:16];
   assign wsq   = w_ff[0] * w_ff[0];
   assign w2_in = wsq[49:8];

   // Stage 4: second order coefficient and cube.
   logic signed [65:0] qp9_in;
   logic signed [66:0] w3r_in, w3r_ff;
   assign qp9_in = q_ff * p9;
   assign w3r_in = w2_ff * w_ff[1];

   // Stage 5: third order coefficient.
   logic signed [58:0] w3;
   logic signed [67:0] w3p10_in, w3p10_ff;
   assign w3       = w3r_ff[66:8];
   assign w3p10_in = w3 * p10;

   // Stage 6: correction sum and corrected estimate.
   logic signed [65:0] qp9_ff [2];
   logic signed [48:0] xp8_ff [4];
   logic signed [52:0] corr;
   logic signed [49:0] f_in, f_ff;
   assign corr = $signed(qp9_ff[1][65:23]) + $signed(xp8_ff[3][48:15])
               + $signed(w3p10_ff[67:17]) + $signed({p7, 15'h0000});
   assign f_in = x_ff[4] + $signed(corr[52:4]);

   // Stage 7: round to pascal, saturate, assemble the result item.
   post_type           pt_ff [POST_STAGES-1];
   logic signed [49:0] fr;
   logic signed [41:0] psh;
   logic [17:0]        press;
   rsp_payload_type    rsp_in, rsp_ff;
   assign fr  = f_ff + 50'sd128;
   assign psh = fr[49:8];
   always_comb begin
      if (psh < 42'sd0) begin
         press = '0;
      end else if (psh > 42'sd262143) begin
         press = 18'h3FFFF;
      end else begin
         press = psh[17:0];
      end
   end

   assign rsp_in.temperature_centi = pt_ff[5].temp;
   assign rsp_in.pressure_pa       = pt_ff[5].inv ? 18'h00000 : press;
   assign rsp_in.pressure_invalid  = pt_ff[5].inv;
   assign rsp_in.humidity_milli    = pt_ff[5].hum;
   assign rsp_in.gas_ohms          = pt_ff[5].gas;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= x_in;
         for (int i = 1; i < 5; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         pt_ff[0] <= pt_in;
         for (int i = 1; i < POST_STAGES - 1; i++) begin
            pt_ff[i] <= pt_ff[i-1];
         end
         xx_ff     <= xx_in;
         w_ff[0]   <= w_in;
         w_ff[1]   <= w_ff[0];
         xp8_ff[0] <= xp8_in;
         for (int i = 1; i < 4; i++) begin
            xp8_ff[i] <= xp8_ff[i-1];
         end
         q_ff      <= q_in;
         w2_ff     <= w2_in;
         qp9_ff[0] <= qp9_in;
         qp9_ff[1] <= qp9_ff[0];
         w3r_ff    <= w3r_in;
         w3p10_ff  <= w3p10_in;
         f_ff      <= f_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
